### src/tfn_pkg.sv
`default_nettype none
package tfn_pkg;

  localparam int CoordBits    = 16;
  localparam int NormFracBits = 14;
  localparam int OutBits      = NormFracBits + 2;
  localparam int EdgeBits     = CoordBits + 1;
  localparam int ProdBits     = 2 * EdgeBits;
  localparam int CrossBits    = 2 * EdgeBits + 1;
  localparam int MagBits      = 2 * EdgeBits;
  localparam int SqBits       = 2 * MagBits;
  localparam int SumBits      = SqBits + 2;
  localparam int RhsBits      = SqBits + 2 * NormFracBits + 2;
  localparam int AccBits      = SumBits + 2 * NormFracBits + 6;
  localparam int QBits        = NormFracBits + 1;
  localparam int FrontStages  = 5;
  localparam int NumStages    = FrontStages + NormFracBits + 2;
  localparam int BitIdxBits   = $clog2(NormFracBits + 1);

  // One component under the digit-by-digit root division.
  typedef struct packed {
    logic [RhsBits-1:0]        rhs;
    logic signed [AccBits-1:0] acc_p;
    logic signed [AccBits-1:0] acc_q;
    logic [QBits-1:0]          quo;
    logic                      neg;
  } comp_t;

  typedef struct packed {
    logic [SumBits-1:0] sum;
    comp_t [2:0]        comp;
    logic               last;
  } step_t;

endpackage
`default_nettype wire

### src/tfn_in_if.sv
`default_nettype none
interface tfn_in_if import tfn_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] ax;
  logic signed [CoordBits-1:0] ay;
  logic signed [CoordBits-1:0] az;
  logic signed [CoordBits-1:0] bx;
  logic signed [CoordBits-1:0] by_coord;
  logic signed [CoordBits-1:0] bz;
  logic signed [CoordBits-1:0] cx;
  logic signed [CoordBits-1:0] cy;
  logic signed [CoordBits-1:0] cz;
  logic                        last_in;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_in,
                  input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_in,
                output ready);
endinterface
`default_nettype wire

### src/tfn_out_if.sv
`default_nettype none
interface tfn_out_if import tfn_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [OutBits-1:0] nx;
  logic signed [OutBits-1:0] ny;
  logic signed [OutBits-1:0] nz;
  logic                      degenerate;
  logic                      last_out;

  modport source (output valid, nx, ny, nz, degenerate, last_out, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, last_out, output ready);
endinterface
`default_nettype wire

### src/triangle_face_normal_top.sv
`default_nettype none
// Pipeline: 5 front stages for edges, cross product, magnitude and squares,
// 15 root division stages and 1 output stage.
// Throughput: one triangle per cycle while the output is ready; every stage advances
// when it is empty or the stage after it moves, so bubbles close up under back pressure.
// Reset clears all valid bits; the data registers are not reset.
module triangle_face_normal_top import tfn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tfn_in_if.sink    tri_in,
  tfn_out_if.source nrm_out
);

  logic [NumStages-1:0] v;
  logic [NumStages-1:0] en;
  step_t                stg [NormFracBits+2];
  logic signed [OutBits-1:0] n_reg [3];
  logic                 degen_reg, last_reg;

  always_comb begin
    en[NumStages-1] = !v[NumStages-1] || nrm_out.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= tri_in.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign tri_in.ready = en[0];

  tfn_front u_front (
    .clk      (clk),
    .en       (en[FrontStages-1:0]),
    .ax       (tri_in.ax),
    .ay       (tri_in.ay),
    .az       (tri_in.az),
    .bx       (tri_in.bx),
    .by_coord (tri_in.by_coord),
    .bz       (tri_in.bz),
    .cx       (tri_in.cx),
    .cy       (tri_in.cy),
    .cz       (tri_in.cz),
    .last_in  (tri_in.last_in),
    .d_out    (stg[0])
  );

  for (genvar k = 0; k <= NormFracBits; k++) begin : g_step
    tfn_root_step u_step (
      .clk     (clk),
      .en      (en[FrontStages+k]),
      .bit_idx (BitIdxBits'(NormFracBits - k)),
      .d_in    (stg[k]),
      .d_out   (stg[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en[NumStages-1]) begin
      for (int i = 0; i < 3; i++) begin
        if (stg[NormFracBits+1].sum == '0) begin
          n_reg[i] <= '0;
        end else if (stg[NormFracBits+1].comp[i].neg) begin
          n_reg[i] <= -$signed(OutBits'(stg[NormFracBits+1].comp[i].quo));
        end else begin
          n_reg[i] <= $signed(OutBits'(stg[NormFracBits+1].comp[i].quo));
        end
      end
      degen_reg <= (stg[NormFracBits+1].sum == '0);
      last_reg  <= stg[NormFracBits+1].last;
    end
  end

  assign nrm_out.valid      = v[NumStages-1];
  assign nrm_out.nx         = n_reg[0];
  assign nrm_out.ny         = n_reg[1];
  assign nrm_out.nz         = n_reg[2];
  assign nrm_out.degenerate = degen_reg;
  assign nrm_out.last_out   = last_reg;

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    nrm_out.valid && nrm_out.degenerate |->
      nrm_out.nx == '0 && nrm_out.ny == '0 && nrm_out.nz == '0)
    else $error("degenerate result with nonzero normal");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !tri_in.ready |-> nrm_out.valid && !nrm_out.ready)
    else $error("input stalled without output back pressure");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    nrm_out.valid |->
      nrm_out.nx <= $signed(OutBits'(1 << NormFracBits)) &&
      nrm_out.nx >= -$signed(OutBits'(1 << NormFracBits)))
    else $error("normal component out of unit range");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !nrm_out.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

### src/tfn_front.sv
`default_nettype none
module tfn_front import tfn_pkg::*; (
  input  logic                        clk,
  input  logic [FrontStages-1:0]      en,
  input  logic signed [CoordBits-1:0] ax,
  input  logic signed [CoordBits-1:0] ay,
  input  logic signed [CoordBits-1:0] az,
  input  logic signed [CoordBits-1:0] bx,
  input  logic signed [CoordBits-1:0] by_coord,
  input  logic signed [CoordBits-1:0] bz,
  input  logic signed [CoordBits-1:0] cx,
  input  logic signed [CoordBits-1:0] cy,
  input  logic signed [CoordBits-1:0] cz,
  input  logic                        last_in,
  output step_t                       d_out
);

  logic signed [EdgeBits-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [ProdBits-1:0] prod [6];
  logic signed [CrossBits-1:0] cross_c [3];
  logic [MagBits-1:0]         mag [3];
  logic [2:0]                 neg1, neg2, neg3;
  logic [SqBits-1:0]          sq [3];
  logic [4:0]                 last_d;
  step_t                      nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1x <= EdgeBits'(bx) - EdgeBits'(ax);
      e1y <= EdgeBits'(by_coord) - EdgeBits'(ay);
      e1z <= EdgeBits'(bz) - EdgeBits'(az);
      e2x <= EdgeBits'(cx) - EdgeBits'(ax);
      e2y <= EdgeBits'(cy) - EdgeBits'(ay);
      e2z <= EdgeBits'(cz) - EdgeBits'(az);
      last_d[0] <= last_in;
    end
    if (en[1]) begin
      prod[0] <= e1y * e2z;
      prod[1] <= e1z * e2y;
      prod[2] <= e1z * e2x;
      prod[3] <= e1x * e2z;
      prod[4] <= e1x * e2y;
      prod[5] <= e1y * e2x;
      last_d[1] <= last_d[0];
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        cross_c[i] <= CrossBits'(prod[2*i]) - CrossBits'(prod[2*i+1]);
      end
      last_d[2] <= last_d[1];
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= cross_c[i][CrossBits-1];
        mag[i]  <= cross_c[i][CrossBits-1] ? MagBits'(-cross_c[i])
                                             : MagBits'(cross_c[i]);
      end
      last_d[3] <= last_d[2];
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SqBits'(mag[i]) * SqBits'(mag[i]);
      end
      neg2      <= neg1;
      last_d[4] <= last_d[3];
    end
  end

  assign neg3 = neg2;

  // Root division starts from u = -1: P = u*u*S = S, Q = u*S = -S.
  always_comb begin
    nxt.sum  = SumBits'(sq[0]) + SumBits'(sq[1]) + SumBits'(sq[2]);
    nxt.last = last_d[4];
    for (int i = 0; i < 3; i++) begin
      nxt.comp[i].rhs   = RhsBits'(sq[i]) << (2 * NormFracBits + 2);
      nxt.comp[i].acc_p = $signed(AccBits'(nxt.sum));
      nxt.comp[i].acc_q = -$signed(AccBits'(nxt.sum));
      nxt.comp[i].quo   = '0;
      nxt.comp[i].neg   = neg3[i];
    end
  end

  assign d_out = nxt;

endmodule
`default_nettype wire

### src/tfn_root_step.sv
`default_nettype none
module tfn_root_step import tfn_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [BitIdxBits-1:0] bit_idx,
  input  step_t                 d_in,
  output step_t                 d_out
);

  // Tries one quotient bit: accept when (2t-1)^2 * S <= c^2 * 2^(2F+2).
  // P = u^2*S and Q = u*S are kept so that each trial is shifts and adds.
  step_t                     nxt;
  logic signed [AccBits-1:0] sum_ext;
  logic signed [AccBits-1:0] cand;
  logic [BitIdxBits+1:0]     sh_p, sh_s, sh_q;

  assign sum_ext = $signed(AccBits'(d_in.sum));
  assign sh_p    = (BitIdxBits+2)'(bit_idx) + (BitIdxBits+2)'(2);
  assign sh_s    = (BitIdxBits+2)'({bit_idx, 1'b0}) + (BitIdxBits+2)'(2);
  assign sh_q    = (BitIdxBits+2)'(bit_idx) + (BitIdxBits+2)'(1);

  always_comb begin
    nxt  = d_in;
    cand = '0;
    for (int i = 0; i < 3; i++) begin
      cand = $signed(d_in.comp[i].acc_p) + ($signed(d_in.comp[i].acc_q) <<< sh_p)
             + (sum_ext <<< sh_s);
      // Once the quotient reaches one, no lower bit may be added.
      if (!d_in.comp[i].quo[QBits-1] &&
          cand <= $signed(AccBits'(d_in.comp[i].rhs))) begin
        nxt.comp[i].acc_p = cand;
        nxt.comp[i].acc_q = $signed(d_in.comp[i].acc_q) + (sum_ext <<< sh_q);
        nxt.comp[i].quo   = d_in.comp[i].quo | (QBits'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule
`default_nettype wire

### tb/sv/tfn_checker.sv
`timescale 1ns / 1ps
module tfn_checker import tfn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tfn_in_if.sink   tri_in,
  tfn_out_if.sink  nrm_out,
  output int       fail_count,
  output int       pending,
  output int       normals_seen,
  output int       flat_seen
);

  typedef struct packed {
    logic [OutBits-1:0] nx;
    logic [OutBits-1:0] ny;
    logic [OutBits-1:0] nz;
    logic               degenerate;
    logic               last_out;
  } normal_t;

  normal_t normal_q[$];
  int mismatches;

  // Rounded c * 2^F / sqrt(sum), ties away from zero, found bit by bit.
  function automatic logic [OutBits-1:0] unit_component(longint c, logic [127:0] sum);
    logic [127:0] mag;
    logic [127:0] rhs;
    logic [127:0] odd;
    logic [127:0] lhs;
    longint q;
    longint t;
    mag = (c < 0) ? -c : c;
    rhs = (mag * mag) << (2 * NormFracBits + 2);
    q = 0;
    for (int b = NormFracBits; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t <= (64'd1 << NormFracBits)) begin
        odd = 2 * t - 1;
        lhs = odd * odd * sum;
        if (lhs <= rhs) q = t;
      end
    end
    if (c < 0) q = -q;
    return q[OutBits-1:0];
  endfunction

  function automatic normal_t face_normal(longint ax, ay, az, bx, by_, bz, cx, cy, cz,
                                          logic last);
    normal_t r;
    longint e1x, e1y, e1z, e2x, e2y, e2z, n0, n1, n2;
    logic [127:0] sum;
    e1x = bx - ax; e1y = by_ - ay; e1z = bz - az;
    e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
    n0 = e1y * e2z - e1z * e2y;
    n1 = e1z * e2x - e1x * e2z;
    n2 = e1x * e2y - e1y * e2x;
    r.last_out = last;
    if (n0 == 0 && n1 == 0 && n2 == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degenerate = 1'b1;
    end else begin
      sum = 128'(n0) * 128'(n0) + 128'(n1) * 128'(n1) + 128'(n2) * 128'(n2);
      r.nx = unit_component(n0, sum);
      r.ny = unit_component(n1, sum);
      r.nz = unit_component(n2, sum);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  assign fail_count = mismatches;

  always @(posedge clk) begin
    normal_t want;
    normal_t got;
    if (rst) begin
      mismatches <= 0;
      normals_seen <= 0;
      flat_seen <= 0;
    end else begin
      if (nrm_out.valid && nrm_out.ready) begin
        got = '{nrm_out.nx, nrm_out.ny, nrm_out.nz, nrm_out.degenerate, nrm_out.last_out};
        normals_seen <= normals_seen + 1;
        if (got.degenerate) flat_seen <= flat_seen + 1;
        if (normal_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected normal %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = normal_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("normal mismatch: expected %p got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (tri_in.valid && tri_in.ready)
        normal_q.push_back(face_normal(tri_in.ax, tri_in.ay, tri_in.az, tri_in.bx,
                                       tri_in.by_coord, tri_in.bz, tri_in.cx, tri_in.cy,
                                       tri_in.cz, tri_in.last_in));
    end
    pending = normal_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tfn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending, normals_seen, flat_seen;
  int random_left;
  bit calm;
  bit long_hold;

  tfn_in_if  tri_in ();
  tfn_out_if nrm_out ();

  triangle_face_normal_top i_dut (.clk(clk), .rst(rst), .tri_in(tri_in), .nrm_out(nrm_out));

  tfn_checker i_check (.clk(clk), .rst(rst), .tri_in(tri_in), .nrm_out(nrm_out),
                       .fail_count(fail_count), .pending(pending),
                       .normals_seen(normals_seen), .flat_seen(flat_seen));

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[triangle_face_normal_top] ERROR");
    $finish;
  end

  initial begin
    tri_in.valid = 1'b0;
    {tri_in.ax, tri_in.ay, tri_in.az, tri_in.bx, tri_in.by_coord, tri_in.bz,
     tri_in.cx, tri_in.cy, tri_in.cz, tri_in.last_in} = '0;
    nrm_out.ready = 1'b0;
    calm = 1'b0;
    long_hold = 1'b0;
  end

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one request and waits for its acceptance.
  task automatic send_triangle(logic [15:0] v[9], logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      tri_in.valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    tri_in.valid <= 1'b1;
    {tri_in.ax, tri_in.ay, tri_in.az, tri_in.bx, tri_in.by_coord, tri_in.bz,
     tri_in.cx, tri_in.cy, tri_in.cz} <= {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    tri_in.last_in <= last;
    @(posedge clk);
    while (!tri_in.ready) @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold while the pipeline fills.
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        nrm_out.ready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        nrm_out.ready <= 1'b0;
        burst = $urandom_range(1, 7);
        repeat (burst - 1) @(posedge clk);
      end else begin
        nrm_out.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [15:0] v[9];
    int mode;
    int wait_cycles;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme corners, flat and collinear triangles, axis-aligned normals.
    for (int k = 0; k < 9; k++) v[k] = 16'h0000;
    send_triangle(v, 1'b0);
    for (int k = 0; k < 9; k++) v[k] = 16'h7fff;
    send_triangle(v, 1'b1);
    v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
          16'h8000, 16'h7fff, 16'h8000};
    send_triangle(v, 1'b0);
    v = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 16'h7fff, 16'h8000};
    send_triangle(v, 1'b1);
    v = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h8000, 16'h8000, 16'h7fff};
    send_triangle(v, 1'b0);
    // Collinear points give a zero cross product.
    v = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6};
    send_triangle(v, 1'b1);
    // Unit axis normals along +z, -z and +y.
    v = '{16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0};
    send_triangle(v, 1'b0);
    v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0};
    send_triangle(v, 1'b0);
    v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0};
    send_triangle(v, 1'b1);
    // Small normals: a 3-4-5 one, a diagonal one and an axis one from negative coordinates.
    v = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd3, 16'd4};
    send_triangle(v, 1'b0);
    v = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1};
    send_triangle(v, 1'b1);
    v = '{16'hffff, 16'hffff, 16'hffff, 16'd1, 16'hffff, 16'hffff,
          16'hffff, 16'hffff, 16'd1};
    send_triangle(v, 1'b0);

    // Long output hold with the sender still offering requests.
    long_hold = 1'b1;
    for (int n = 0; n < 60; n++) begin
      for (int k = 0; k < 9; k++) v[k] = 16'($urandom);
      send_triangle(v, 1'($urandom));
    end

    random_left = 890;
    while (random_left > 0) begin
      if (random_left < 150) calm = 1'b1;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) begin
        if (mode == 0) v[k] = pick_coord($urandom_range(0, 3));
        else if (mode == 1) v[k] = pick_coord(2);
        else v[k] = pick_coord(3);
      end
      // Occasionally repeat a vertex or make the edges parallel.
      if (mode == 2) {v[3], v[4], v[5]} = {v[0], v[1], v[2]};
      if (mode == 3) {v[6], v[7], v[8]} = {v[3], v[4], v[5]};
      send_triangle(v, 1'($urandom));
      random_left--;
    end
    tri_in.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    $display("Checked %0d face normals, %0d of them degenerate,", normals_seen, flat_seen);
    $display("with extreme coordinates, random stalls and one long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("[triangle_face_normal_top] OK");
    end else begin
      $display("[triangle_face_normal_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/tfn_pkg.sv
src/tfn_in_if.sv
src/tfn_out_if.sv
src/tfn_front.sv
src/tfn_root_step.sv
src/triangle_face_normal_top.sv
tb/sv/tfn_checker.sv
tb/sv/testbench.sv
